[src/asc_pkg.sv]
// asc_pkg: shared widths, payload types and sequencer states for the array statistics core
// used by every module under src; depends on nothing
`default_nettype none
package asc_pkg;
   localparam int MAX_COUNT = 64;
   localparam int SAMPLE_W  = 16;
   localparam int ADDR_W    = $clog2(MAX_COUNT);
   localparam int CNT_W     = $clog2(MAX_COUNT + 1);
   localparam int SUM_W     = $clog2(MAX_COUNT * 65535 + 1);
   localparam int DIV_CNT_W = $clog2(SUM_W + 1);
   localparam int COUNT_W   = 7;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
   } req_payload_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] mean;
      logic [SAMPLE_W-1:0] maximum;
      logic [SAMPLE_W-1:0] minimum;
      logic [SAMPLE_W-1:0] median;
      logic [SAMPLE_W-1:0] most_frequent;
      logic [COUNT_W-1:0]  sample_count;
      logic                overflowed;
   } rsp_payload_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SORT_INIT,
      ST_SORT_RDI,
      ST_SORT_RDV,
      ST_SORT_RDJ,
      ST_SORT_CMP,
      ST_SORT_NEXT,
      ST_MED_RD0,
      ST_MED_RD1,
      ST_MED_SET,
      ST_MODE_RD0,
      ST_MODE_RD,
      ST_MODE_CMP,
      ST_DIV,
      ST_OUT
   } state_type;
endpackage
`default_nettype wire

[src/asc_store.sv]
// asc_store: sample memory, one write port and one registered read port
// depends on asc_pkg
`default_nettype none
module asc_store
   import asc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                we,
   input  wire logic [ADDR_W-1:0]   waddr,
   input  wire logic [SAMPLE_W-1:0] wdata,
   input  wire logic [ADDR_W-1:0]   raddr,
   output logic      [SAMPLE_W-1:0] rdata
);
   logic [SAMPLE_W-1:0] mem [MAX_COUNT];
   logic [SAMPLE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

[src/asc_div.sv]
// asc_div: restoring divider, one quotient bit per cycle
// depends on asc_pkg
`default_nettype none
module asc_div
   import asc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SUM_W-1:0] dividend,
   input  wire logic [CNT_W-1:0] divisor,
   output div_status_type        status,
   output logic      [SUM_W-1:0] quotient
);
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]     div_ff, div_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W:0]       shifted;
   logic                 fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[SUM_W-1]};
      fits    = shifted >= {1'b0, div_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = DIV_CNT_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[SUM_W-2:0], fits};
         rem_in = fits ? CNT_W'(shifted - {1'b0, div_ff}) : shifted[CNT_W-1:0];
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
endmodule
`default_nettype wire

[src/array_statistics_core.sv]
// array_statistics_core: loads a sample set, sorts it in memory, gives mean, extremes,
// median, most frequent value, count and overflow flag; depends on asc_pkg, asc_store, asc_div
//
//   channel  dir  payload           handshake
//   req_     in   sample, last      req_valid / req_stall
//   rsp_     out  statistics        rsp_valid / rsp_stall
//
// samples load one per cycle; after last, an insertion sort runs over the memory through its
// one write port and one registered read port, then the median is read, a run scan finds the
// most frequent value and the divider forms the mean
// reset is synchronous and clears the sequencer and running values, not the memory
// req_stall is high from the last sample until the result is taken; rsp holds while stalled
`default_nettype none
module array_statistics_core
   import asc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_payload
);
   state_type state_ff, state_in;

   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0] max_ff, max_in;
   logic [SAMPLE_W-1:0] min_ff, min_in;
   logic                drop_ff, drop_in;
   logic [CNT_W-1:0]    i_ff, i_in;
   logic [CNT_W-1:0]    j_ff, j_in;
   logic [SAMPLE_W-1:0] v_ff, v_in;
   logic [SAMPLE_W-1:0] med_ff, med_in;
   logic [SAMPLE_W-1:0] cur_ff, cur_in;
   logic [SAMPLE_W-1:0] best_ff, best_in;
   logic [CNT_W-1:0]    run_ff, run_in;
   logic [CNT_W-1:0]    best_run_ff, best_run_in;

   logic                we;
   logic [ADDR_W-1:0]   waddr;
   logic [SAMPLE_W-1:0] wdata;
   logic [ADDR_W-1:0]   raddr;
   logic [SAMPLE_W-1:0] rdata;
   logic                div_start;
   div_status_type      div_status;
   logic [SUM_W-1:0]    quotient;
   logic [CNT_W-1:0]    mid;
   logic                accept;
   logic [SAMPLE_W:0]   pair_sum;

   asc_store u_store (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   asc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (fill_ff),
      .status   (div_status),
      .quotient (quotient)
   );

   assign accept   = req_valid && !req_stall;
   assign mid      = fill_ff >> 1;
   assign pair_sum = {1'b0, v_ff} + {1'b0, rdata};

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      sum_in      = sum_ff;
      max_in      = max_ff;
      min_in      = min_ff;
      drop_in     = drop_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      v_in        = v_ff;
      med_in      = med_ff;
      cur_in      = cur_ff;
      best_in     = best_ff;
      run_in      = run_ff;
      best_run_in = best_run_ff;
      we          = 1'b0;
      waddr       = fill_ff[ADDR_W-1:0];
      wdata       = req_payload.sample;
      raddr       = i_ff[ADDR_W-1:0];
      div_start   = 1'b0;
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            if (accept) begin
               if (fill_ff < CNT_W'(MAX_COUNT)) begin
                  we      = 1'b1;
                  fill_in = fill_ff + CNT_W'(1);
                  sum_in  = sum_ff + SUM_W'(req_payload.sample);
                  if (req_payload.sample > max_ff) max_in = req_payload.sample;
                  if (req_payload.sample < min_ff) min_in = req_payload.sample;
               end else begin
                  drop_in = 1'b1;
               end
               if (req_payload.last) state_in = ST_SORT_INIT;
            end
         end
         ST_SORT_INIT: begin
            i_in     = CNT_W'(1);
            state_in = (fill_ff > CNT_W'(1)) ? ST_SORT_RDI : ST_MED_RD0;
         end
         ST_SORT_RDI: begin
            raddr    = i_ff[ADDR_W-1:0];
            state_in = ST_SORT_RDV;
         end
         ST_SORT_RDV: begin
            v_in     = rdata;
            j_in     = i_ff;
            state_in = ST_SORT_RDJ;
         end
         ST_SORT_RDJ: begin
            if (j_ff == '0) begin
               we       = 1'b1;
               waddr    = '0;
               wdata    = v_ff;
               state_in = ST_SORT_NEXT;
            end else begin
               raddr    = ADDR_W'(j_ff - CNT_W'(1));
               state_in = ST_SORT_CMP;
            end
         end
         ST_SORT_CMP: begin
            we    = 1'b1;
            waddr = j_ff[ADDR_W-1:0];
            if (rdata > v_ff) begin
               wdata    = rdata;
               j_in     = j_ff - CNT_W'(1);
               state_in = ST_SORT_RDJ;
            end else begin
               wdata    = v_ff;
               state_in = ST_SORT_NEXT;
            end
         end
         ST_SORT_NEXT: begin
            i_in     = i_ff + CNT_W'(1);
            state_in = (i_ff + CNT_W'(1) >= fill_ff) ? ST_MED_RD0 : ST_SORT_RDI;
         end
         ST_MED_RD0: begin
            raddr    = fill_ff[0] ? mid[ADDR_W-1:0] : ADDR_W'(mid - CNT_W'(1));
            state_in = ST_MED_RD1;
         end
         ST_MED_RD1: begin
            v_in     = rdata;
            raddr    = mid[ADDR_W-1:0];
            state_in = ST_MED_SET;
         end
         ST_MED_SET: begin
            med_in   = fill_ff[0] ? v_ff : pair_sum[SAMPLE_W:1];
            raddr    = '0;
            state_in = ST_MODE_RD0;
         end
         ST_MODE_RD0: begin
            cur_in      = rdata;
            best_in     = rdata;
            run_in      = CNT_W'(1);
            best_run_in = '0;
            i_in        = CNT_W'(1);
            state_in    = ST_MODE_RD;
         end
         ST_MODE_RD: begin
            if (i_ff == fill_ff) begin
               if (run_ff > best_run_ff) best_in = cur_ff;
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               raddr    = i_ff[ADDR_W-1:0];
               state_in = ST_MODE_CMP;
            end
         end
         ST_MODE_CMP: begin
            if (rdata == cur_ff) begin
               run_in = run_ff + CNT_W'(1);
            end else begin
               if (run_ff > best_run_ff) begin
                  best_run_in = run_ff;
                  best_in     = cur_ff;
               end
               run_in = CNT_W'(1);
               cur_in = rdata;
            end
            i_in     = i_ff + CNT_W'(1);
            state_in = ST_MODE_RD;
         end
         ST_DIV: begin
            if (div_status.done) state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               fill_in  = '0;
               sum_in   = '0;
               max_in   = '0;
               min_in   = '1;
               drop_in  = 1'b0;
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         fill_ff  <= '0;
         sum_ff   <= '0;
         max_ff   <= '0;
         min_ff   <= '1;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         sum_ff   <= sum_in;
         max_ff   <= max_in;
         min_ff   <= min_in;
         drop_ff  <= drop_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      v_ff        <= v_in;
      med_ff      <= med_in;
      cur_ff      <= cur_in;
      best_ff     <= best_in;
      run_ff      <= run_in;
      best_run_ff <= best_run_in;
   end

   assign rsp_payload.mean          = quotient[SAMPLE_W-1:0];
   assign rsp_payload.maximum       = max_ff;
   assign rsp_payload.minimum       = min_ff;
   assign rsp_payload.median        = med_ff;
   assign rsp_payload.most_frequent = best_ff;
   assign rsp_payload.sample_count  = COUNT_W'(fill_ff);
   assign rsp_payload.overflowed    = drop_ff;
endmodule
`default_nettype wire

[src/asc_checker.sv]
// asc_checker: port-level assertions for array_statistics_core, with its bind
// depends on asc_pkg
`default_nettype none
module asc_checker
   import asc_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_stall,
   input wire req_payload_type req_payload,
   input wire logic            rsp_valid,
   input wire logic            rsp_stall,
   input wire rsp_payload_type rsp_payload
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result item changed while stalled");

   a_busy_when_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while result pending");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.sample_count != '0)
      else $error("result with empty set");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.minimum <= rsp_payload.median
         && rsp_payload.median <= rsp_payload.maximum
         && rsp_payload.minimum <= rsp_payload.mean
         && rsp_payload.mean <= rsp_payload.maximum)
      else $error("statistics out of order");
endmodule

bind array_statistics_core asc_checker u_asc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
`default_nettype wire

[bench/tb.sv]
// tb: random and directed test of array_statistics_core, checks every statistics item
// against a behavioral predictor; depends on asc_pkg and the core under src
`default_nettype none
module tb;
   import asc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 200000;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   array_statistics_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   always #5 clock = ~clock;

   req_payload_type pending_samples[$];
   rsp_payload_type expected_stats[$];
   logic [15:0]     set_values[$];
   logic            set_dropped = 1'b0;
   int              mismatch_count = 0;
   int              quiet_cycles = 0;
   bit              calm_phase = 1'b0;
   bit              hold_output = 1'b0;
   int              hold_cycles = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("tb: mismatch %s got %0d expected %0d", what, got, want);
      mismatch_count++;
   endtask

   // accepted sample updates the set; closing sample yields expected statistics
   task automatic absorb_sample(input req_payload_type item);
      logic [15:0]     sorted[$];
      rsp_payload_type stats;
      longint          total;
      int              n, run, best_run;
      logic [15:0]     cur;
      if (set_values.size() < MAX_COUNT) set_values.push_back(item.sample);
      else set_dropped = 1'b1;
      if (!item.last) return;
      sorted = set_values;
      sorted.sort();
      n = sorted.size();
      total = 0;
      foreach (sorted[i]) total += sorted[i];
      stats.mean = 16'(total / n);
      stats.maximum = sorted[n-1];
      stats.minimum = sorted[0];
      if (n % 2 == 0) stats.median = 16'((32'(sorted[n/2-1]) + sorted[n/2]) / 2);
      else stats.median = sorted[n/2];
      cur = sorted[0];
      run = 1;
      best_run = 0;
      stats.most_frequent = sorted[0];
      for (int i = 1; i < n; i++) begin
         if (sorted[i] == cur) run++;
         else begin
            if (run > best_run) begin
               best_run = run;
               stats.most_frequent = cur;
            end
            run = 1;
            cur = sorted[i];
         end
      end
      if (run > best_run) stats.most_frequent = cur;
      stats.sample_count = 7'(n);
      stats.overflowed = set_dropped;
      expected_stats.push_back(stats);
      set_values.delete();
      set_dropped = 1'b0;
   endtask

   function automatic logic [15:0] random_sample(input int flavor);
      case (flavor)
         0: return 16'($urandom_range(0, 3));
         1: return 16'($urandom_range(65532, 65535));
         2: return 16'($urandom_range(0, 15) * 4096);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_set(input int n, input int flavor);
      req_payload_type item;
      for (int i = 0; i < n; i++) begin
         item.sample = random_sample(flavor);
         item.last = (i == n - 1);
         pending_samples.push_back(item);
      end
   endtask

   task automatic queue_fixed(input logic [15:0] value, input int n);
      req_payload_type item;
      for (int i = 0; i < n; i++) begin
         item.sample = value;
         item.last = (i == n - 1);
         pending_samples.push_back(item);
      end
   endtask

   // driver
   int send_gap = 0;
   bit req_taken = 1'b0;
   always @(posedge clock) req_taken <= !reset && req_valid && !req_stall;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            absorb_sample(req_payload);
            void'(pending_samples.pop_front());
         end
         if (!req_valid || req_taken) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               if (!calm_phase && $urandom_range(0, 15) == 0) begin
                  send_gap = $urandom_range(0, 9);
                  req_valid <= 1'b0;
               end else begin
                  req_valid <= 1'b1;
                  req_payload <= pending_samples[0];
               end
            end else req_valid <= 1'b0;
         end
      end
   end

   // receiver stall
   int stall_left = 0;
   always @(negedge clock) begin
      if (hold_output) rsp_stall <= 1'b1;
      else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!calm_phase && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else rsp_stall <= 1'b0;
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > QUIET_LIMIT) begin
            $display("tb: errors");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_stats.size() == 0) begin
               $display("tb: unexpected statistics item");
               mismatch_count++;
            end else begin
               rsp_payload_type want;
               want = expected_stats.pop_front();
               if (rsp_payload.mean !== want.mean)
                  report_mismatch("mean", rsp_payload.mean, want.mean);
               if (rsp_payload.maximum !== want.maximum)
                  report_mismatch("maximum", rsp_payload.maximum, want.maximum);
               if (rsp_payload.minimum !== want.minimum)
                  report_mismatch("minimum", rsp_payload.minimum, want.minimum);
               if (rsp_payload.median !== want.median)
                  report_mismatch("median", rsp_payload.median, want.median);
               if (rsp_payload.most_frequent !== want.most_frequent)
                  report_mismatch("most_frequent", rsp_payload.most_frequent,
                                  want.most_frequent);
               if (rsp_payload.sample_count !== want.sample_count)
                  report_mismatch("sample_count", rsp_payload.sample_count,
                                  want.sample_count);
               if (rsp_payload.overflowed !== want.overflowed)
                  report_mismatch("overflowed", rsp_payload.overflowed, want.overflowed);
            end
         end
      end
   end

   task automatic drain_all();
      while (pending_samples.size() > 0 || req_valid || expected_stats.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      req_payload_type item;
      int total;
      logic [15:0] odd_set[5];
      logic [15:0] even_set[4];
      odd_set = '{16'd7, 16'd3, 16'd3, 16'd7, 16'd5};
      even_set = '{16'h5555, 16'hAAAA, 16'h0001, 16'h8000};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed sets: single sample, extremes, even/odd median, ties
      queue_fixed(16'h0000, 1);
      queue_fixed(16'hFFFF, 1);
      item.sample = 16'hFFFF; item.last = 1'b0; pending_samples.push_back(item);
      item.sample = 16'h0000; item.last = 1'b1; pending_samples.push_back(item);
      foreach (odd_set[i]) begin
         item.sample = odd_set[i];
         item.last = (i == 4);
         pending_samples.push_back(item);
      end
      foreach (even_set[i]) begin
         item.sample = even_set[i];
         item.last = (i == 3);
         pending_samples.push_back(item);
      end
      queue_set(9, 0);
      drain_all();

      // full store, then overflow with last on a dropped sample
      queue_fixed(16'hFFFF, MAX_COUNT);
      queue_set(MAX_COUNT + 3, 3);
      drain_all();

      // long receiver hold while the sender keeps offering
      hold_output = 1'b1;
      queue_set(5, 3);
      queue_set(6, 0);
      hold_cycles = 0;
      while (hold_cycles < 300) begin
         @(posedge clock);
         hold_cycles++;
      end
      hold_output = 1'b0;
      drain_all();

      total = 0;
      while (total < 990) begin
         int n;
         if ($urandom_range(0, 19) == 0) n = $urandom_range(MAX_COUNT - 2, MAX_COUNT + 4);
         else n = $urandom_range(1, 12);
         if (total > 820) calm_phase = 1'b1;
         queue_set(n, $urandom_range(0, 4));
         total += n;
         if ($urandom_range(0, 9) == 0) drain_all();
         while (pending_samples.size() > 40) @(posedge clock);
      end
      drain_all();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end
endmodule
`default_nettype wire

[files.f]
src/asc_pkg.sv
src/asc_store.sv
src/asc_div.sv
src/array_statistics_core.sv
src/asc_checker.sv
bench/tb.sv
